[src/wac_pkg.sv]
// Shared constants and codes for the wildcard rule access check block.
// No dependencies; imported by wac_cell, wildcard_rule_access_check and the bench.
`timescale 1ns / 1ps
`default_nettype none

package wac_pkg;

  localparam int MAX_RULES_DEF = 64;
  localparam int ID_WIDTH_DEF  = 16;

  // Fixed port widths
  localparam int FIELD_W  = 16;
  localparam int RN_OUT_W = 7;
  localparam int REV_W    = 32;

  localparam logic [REV_W-1:0] REV_RESET = 32'd1;

  typedef enum logic {
    FUNC_CHECK  = 1'b0,
    FUNC_APPEND = 1'b1
  } func_t;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_t;

endpackage

`default_nettype wire

[src/wac_cell.sv]
// One rule cell of the check chain: holds a stored rule and applies it to the
// query beat passing through. Depends on wac_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

module wac_cell import wac_pkg::*; #(
  parameter int ID_WIDTH = ID_WIDTH_DEF,
  parameter int NUM_W    = $clog2(MAX_RULES_DEF + 1),
  parameter int INDEX    = 0
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire logic                wr_en,
  input  wire logic                in_use,
  input  wire logic                wr_allow,
  input  wire logic [ID_WIDTH-1:0] wr_subj,
  input  wire logic [ID_WIDTH-1:0] wr_oper,
  input  wire logic [ID_WIDTH-1:0] wr_obj,
  input  wire logic                in_valid,
  input  wire logic [ID_WIDTH-1:0] in_subj,
  input  wire logic [ID_WIDTH-1:0] in_oper,
  input  wire logic [ID_WIDTH-1:0] in_obj,
  input  wire logic                in_allowed,
  input  wire logic [NUM_W-1:0]    in_number,
  output logic                     out_valid,
  output logic [ID_WIDTH-1:0]      out_subj,
  output logic [ID_WIDTH-1:0]      out_oper,
  output logic [ID_WIDTH-1:0]      out_obj,
  output logic                     out_allowed,
  output logic [NUM_W-1:0]         out_number
);

  localparam logic [NUM_W-1:0] MY_NUMBER = NUM_W'(INDEX + 1);

  logic                rule_allow;
  logic [ID_WIDTH-1:0] rule_subj;
  logic [ID_WIDTH-1:0] rule_oper;
  logic [ID_WIDTH-1:0] rule_obj;
  logic                hit;

  // Zero in a rule field is the wildcard
  assign hit = in_use &&
               ((rule_subj == '0) || (rule_subj == in_subj)) &&
               ((rule_oper == '0) || (rule_oper == in_oper)) &&
               ((rule_obj  == '0) || (rule_obj  == in_obj));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule_allow <= wr_allow;
      rule_subj  <= wr_subj;
      rule_oper  <= wr_oper;
      rule_obj   <= wr_obj;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // Later hits override earlier ones: last match decides
  always_ff @(posedge clk) begin
    if (adv) begin
      out_subj    <= in_subj;
      out_oper    <= in_oper;
      out_obj     <= in_obj;
      out_allowed <= hit ? rule_allow : in_allowed;
      out_number  <= hit ? MY_NUMBER : in_number;
    end
  end

endmodule

`default_nettype wire

[src/wildcard_rule_access_check.sv]
// Wildcard rule access check: last-match access-control list in a chain of rule cells.
// Append: result registered in the cycle after the input beat is taken. Check: the query
// walks one cell per cycle unless a stalled output freezes the chain, then is registered
// at the output; one item in flight, no new beat taken while a check is in the chain.
// Reset (rst, sync): empty table, revision 1, chain and output cleared; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_rule_access_check import wac_pkg::*; #(
  parameter int MAX_RULES = MAX_RULES_DEF,
  parameter int ID_WIDTH  = ID_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                func,
  input  wire logic                allow,
  input  wire logic [FIELD_W-1:0]  subject_id,
  input  wire logic [FIELD_W-1:0]  operation_id,
  input  wire logic [FIELD_W-1:0]  target_id,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     status,
  output logic                     allowed,
  output logic [RN_OUT_W-1:0]      rule_num,
  output logic [REV_W-1:0]         revision
);

  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_RULES);

  logic [CNT_W-1:0]          rules_in_use;
  logic [REV_W-1:0]          policy_rev;
  logic                      busy;

  logic                      in_acc;
  logic                      app_acc;
  logic                      chk_acc;
  logic                      table_full;
  logic                      adv;
  logic                      tail_valid;
  logic                      tail_take;

  logic [ID_WIDTH+FIELD_W-1:0] subj_ext;
  logic [ID_WIDTH+FIELD_W-1:0] oper_ext;
  logic [ID_WIDTH+FIELD_W-1:0] obj_ext;
  logic [ID_WIDTH-1:0]         q_subj;
  logic [ID_WIDTH-1:0]         q_oper;
  logic [ID_WIDTH-1:0]         q_obj;

  logic [CNT_W-1:0]            app_number;
  logic [CNT_W+RN_OUT_W-1:0]   app_num_ext;
  logic [CNT_W+RN_OUT_W-1:0]   chk_num_ext;

  // Token path: index 0 is the injection point, index k the output of cell k-1
  logic                tok_valid   [MAX_RULES+1];
  logic [ID_WIDTH-1:0] tok_subj    [MAX_RULES+1];
  logic [ID_WIDTH-1:0] tok_oper    [MAX_RULES+1];
  logic [ID_WIDTH-1:0] tok_obj     [MAX_RULES+1];
  logic                tok_allowed [MAX_RULES+1];
  logic [CNT_W-1:0]    tok_number  [MAX_RULES+1];
  logic [MAX_RULES-1:0] chain_valid;

  // Identifiers taken modulo 2^ID_WIDTH
  assign subj_ext = {{ID_WIDTH{1'b0}}, subject_id};
  assign oper_ext = {{ID_WIDTH{1'b0}}, operation_id};
  assign obj_ext  = {{ID_WIDTH{1'b0}}, target_id};
  assign q_subj   = subj_ext[ID_WIDTH-1:0];
  assign q_oper   = oper_ext[ID_WIDTH-1:0];
  assign q_obj    = obj_ext[ID_WIDTH-1:0];

  assign in_stall   = busy || (out_valid && out_stall);
  assign in_acc     = in_valid && !in_stall;
  assign app_acc    = in_acc && (func == FUNC_APPEND);
  assign chk_acc    = in_acc && (func == FUNC_CHECK);
  assign table_full = (rules_in_use == FULL_CNT);

  assign tail_valid = tok_valid[MAX_RULES];
  // Freeze the chain while a finished check waits for a full output register
  assign adv        = !(tail_valid && out_valid && out_stall);
  assign tail_take  = tail_valid && adv;

  assign app_number  = rules_in_use + CNT_W'(1);
  assign app_num_ext = {{RN_OUT_W{1'b0}}, app_number};
  assign chk_num_ext = {{RN_OUT_W{1'b0}}, tok_number[MAX_RULES]};

  assign tok_valid[0]   = chk_acc;
  assign tok_subj[0]    = q_subj;
  assign tok_oper[0]    = q_oper;
  assign tok_obj[0]     = q_obj;
  assign tok_allowed[0] = 1'b0;
  assign tok_number[0]  = '0;

  for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
    logic wr_en;
    logic in_use;

    assign wr_en  = app_acc && !table_full && (rules_in_use == CNT_W'(i));
    assign in_use = (rules_in_use > CNT_W'(i));
    assign chain_valid[i] = tok_valid[i+1];

    wac_cell #(
      .ID_WIDTH (ID_WIDTH),
      .NUM_W    (CNT_W),
      .INDEX    (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .adv         (adv),
      .wr_en       (wr_en),
      .in_use      (in_use),
      .wr_allow    (allow),
      .wr_subj     (q_subj),
      .wr_oper     (q_oper),
      .wr_obj      (q_obj),
      .in_valid    (tok_valid[i]),
      .in_subj     (tok_subj[i]),
      .in_oper     (tok_oper[i]),
      .in_obj      (tok_obj[i]),
      .in_allowed  (tok_allowed[i]),
      .in_number   (tok_number[i]),
      .out_valid   (tok_valid[i+1]),
      .out_subj    (tok_subj[i+1]),
      .out_oper    (tok_oper[i+1]),
      .out_obj     (tok_obj[i+1]),
      .out_allowed (tok_allowed[i+1]),
      .out_number  (tok_number[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rules_in_use <= '0;
      policy_rev   <= REV_RESET;
      busy         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (app_acc && !table_full) begin
        rules_in_use <= app_number;
        policy_rev   <= policy_rev + REV_W'(1);
      end
      priority if (chk_acc) begin
        busy <= 1'b1;
      end else if (tail_take) begin
        busy <= 1'b0;
      end
      priority if (app_acc || tail_take) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output beat payload
  always_ff @(posedge clk) begin
    priority if (app_acc) begin
      allowed <= 1'b0;
      if (table_full) begin
        status   <= STATUS_FULL;
        rule_num <= '0;
        revision <= policy_rev;
      end else begin
        status   <= STATUS_OK;
        rule_num <= app_num_ext[RN_OUT_W-1:0];
        revision <= policy_rev + REV_W'(1);
      end
    end else if (tail_take) begin
      status   <= STATUS_OK;
      allowed  <= tok_allowed[MAX_RULES];
      rule_num <= chk_num_ext[RN_OUT_W-1:0];
      revision <= policy_rev;
    end
  end

  a_one_token : assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one query beat in the cell chain");

  a_token_busy : assert property (@(posedge clk) disable iff (rst)
    (chain_valid != '0) |-> busy)
    else $error("query beat in chain while not busy");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    (app_acc && !table_full) |=> (rules_in_use == $past(rules_in_use) + CNT_W'(1)))
    else $error("rule count did not advance on append");

  a_rev_hold : assert property (@(posedge clk) disable iff (rst)
    !(app_acc && !table_full) |=> $stable(policy_rev))
    else $error("revision changed without a stored rule");

  a_count_max : assert property (@(posedge clk) disable iff (rst)
    rules_in_use <= FULL_CNT)
    else $error("rule count beyond table size");

endmodule

`default_nettype wire

[tb/wildcard_rule_access_check_tb.sv]
// Self-checking bench for wildcard_rule_access_check: directed table, then random appends/checks.
// Expected verdicts come from a last-match ACL predictor kept in the bench; needs wac_pkg.
`timescale 1ns / 1ps

module wildcard_rule_access_check_tb import wac_pkg::*;;

  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_SHOWN    = 10;

  typedef struct packed {
    logic               allow;
    logic [FIELD_W-1:0] subj;
    logic [FIELD_W-1:0] oper;
    logic [FIELD_W-1:0] obj;
  } acl_rule_t;

  typedef struct packed {
    status_t             status;
    logic                allowed;
    logic [RN_OUT_W-1:0] rule_num;
    logic [REV_W-1:0]    revision;
  } verdict_t;

  typedef struct packed {
    func_t              f;
    logic               allow;
    logic [FIELD_W-1:0] subj;
    logic [FIELD_W-1:0] oper;
    logic [FIELD_W-1:0] obj;
    bit                 typed;
    verdict_t           want;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                func;
  logic                allow;
  logic [FIELD_W-1:0]  subject_id;
  logic [FIELD_W-1:0]  operation_id;
  logic [FIELD_W-1:0]  target_id;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                status;
  logic                allowed;
  logic [RN_OUT_W-1:0] rule_num;
  logic [REV_W-1:0]    revision;

  wildcard_rule_access_check u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .allow       (allow),
    .subject_id  (subject_id),
    .operation_id(operation_id),
    .target_id   (target_id),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .allowed     (allowed),
    .rule_num    (rule_num),
    .revision    (revision)
  );

  // Predictor state
  acl_rule_t        policy [MAX_RULES_DEF];
  int               rules_held = 0;
  logic [REV_W-1:0] cur_rev = REV_RESET;

  verdict_t pending_verdicts [$];

  logic [FIELD_W-1:0] id_pool [3][8];
  bit  quiet_phase = 1'b0;
  int  rx_hold = 0;
  int  cycle_count = 0;
  int  fail_count = 0;
  int  n_checks = 0;
  int  n_hits = 0;
  int  n_appends = 0;
  int  n_full = 0;

  dir_row_t dir_rows [17];

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding",
               cycle_count, pending_verdicts.size());
      $display("wildcard_rule_access_check test failed");
      $finish;
    end
  end

  function automatic int idle_draw();
    return quiet_phase ? 0 : $urandom_range(0, 7);
  endfunction

  // Last-match scan over stored rules; appends bump the revision unless full.
  function automatic verdict_t apply_to_policy(func_t f, logic a, logic [FIELD_W-1:0] s,
                                               logic [FIELD_W-1:0] o, logic [FIELD_W-1:0] b);
    verdict_t v;
    v = '0;
    v.status = STATUS_OK;
    if (f == FUNC_APPEND) begin
      if (rules_held >= MAX_RULES_DEF) begin
        v.status = STATUS_FULL;
        n_full++;
      end else begin
        policy[rules_held] = '{a, s, o, b};
        rules_held++;
        v.rule_num = RN_OUT_W'(rules_held);
        cur_rev = cur_rev + 1'b1;
        n_appends++;
      end
    end else begin
      n_checks++;
      for (int i = 0; i < rules_held; i++) begin
        if ((policy[i].subj == '0 || policy[i].subj == s) &&
            (policy[i].oper == '0 || policy[i].oper == o) &&
            (policy[i].obj  == '0 || policy[i].obj  == b)) begin
          v.allowed  = policy[i].allow;
          v.rule_num = RN_OUT_W'(i + 1);
        end
      end
      if (v.rule_num != '0) n_hits++;
    end
    v.revision = cur_rev;
    return v;
  endfunction

  // Rules lean on the wildcard more than queries do.
  function automatic logic [FIELD_W-1:0] pick_id(int field, bit for_rule);
    int r;
    r = $urandom_range(0, 9);
    if (r < (for_rule ? 3 : 1)) return '0;
    if (r == 9) return FIELD_W'($urandom);
    return id_pool[field][$urandom_range(0, 7)];
  endfunction

  task automatic send_beat(func_t f, logic a, logic [FIELD_W-1:0] s, logic [FIELD_W-1:0] o,
                           logic [FIELD_W-1:0] b, bit typed, verdict_t want);
    int gap;
    verdict_t got;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= f;
    allow        <= a;
    subject_id   <= s;
    operation_id <= o;
    target_id    <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = apply_to_policy(f, a, s, o, b);
    pending_verdicts.push_back(typed ? want : got);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  // Receiver: new hold-off drawn after every taken beat.
  always @(posedge clk) begin
    if (out_valid && !out_stall) rx_hold = idle_draw();
    else if (rx_hold > 0) rx_hold = rx_hold - 1;
    out_stall <= (rx_hold > 0);
  end

  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN)
          $display("unexpected result: status=%0d allowed=%0d rule=%0d rev=%0d",
                   status, allowed, rule_num, revision);
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (exp_v.status !== status || exp_v.allowed !== allowed ||
            exp_v.rule_num !== rule_num || exp_v.revision !== revision) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("mismatch: exp status=%0d allowed=%0d rule=%0d rev=%0d, got %0d %0d %0d %0d",
                     exp_v.status, exp_v.allowed, exp_v.rule_num, exp_v.revision,
                     status, allowed, rule_num, revision);
        end
      end
    end
  end

  initial begin
    func_t f;
    rst          = 1'b1;
    in_valid     = 1'b0;
    func         = 1'b0;
    allow        = 1'b0;
    subject_id   = '0;
    operation_id = '0;
    target_id    = '0;

    for (int k = 0; k < 3; k++) begin
      id_pool[k][0] = 16'hFFFF;
      id_pool[k][1] = 16'h0001;
      for (int j = 2; j < 8; j++) id_pool[k][j] = FIELD_W'($urandom_range(1, 65535));
    end

    // typed rows: empty table and first appends; the rest go through the predictor
    dir_rows[0]  = '{FUNC_CHECK,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                     '{STATUS_OK, 1'b0, 7'd0, 32'd1}};
    dir_rows[1]  = '{FUNC_CHECK,  1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                     '{STATUS_OK, 1'b0, 7'd0, 32'd1}};
    dir_rows[2]  = '{FUNC_APPEND, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                     '{STATUS_OK, 1'b0, 7'd1, 32'd2}};
    dir_rows[3]  = '{FUNC_CHECK,  1'b0, 16'h0005, 16'h0006, 16'h0007, 1'b0, '0};
    dir_rows[4]  = '{FUNC_APPEND, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                     '{STATUS_OK, 1'b0, 7'd2, 32'd3}};
    dir_rows[5]  = '{FUNC_CHECK,  1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0};
    dir_rows[6]  = '{FUNC_CHECK,  1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFE, 1'b0, '0};
    dir_rows[7]  = '{FUNC_APPEND, 1'b1, 16'h1234, 16'h0000, 16'h0000, 1'b0, '0};
    dir_rows[8]  = '{FUNC_APPEND, 1'b0, 16'h0000, 16'h00A5, 16'h0000, 1'b0, '0};
    dir_rows[9]  = '{FUNC_APPEND, 1'b1, 16'h0000, 16'h0000, 16'h8001, 1'b0, '0};
    dir_rows[10] = '{FUNC_CHECK,  1'b0, 16'h1234, 16'h00A5, 16'h8001, 1'b0, '0};
    // zero in a query is an ordinary id, not a wildcard
    dir_rows[11] = '{FUNC_CHECK,  1'b0, 16'h1234, 16'h00A5, 16'h0000, 1'b0, '0};
    dir_rows[12] = '{FUNC_CHECK,  1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0};
    dir_rows[13] = '{FUNC_APPEND, 1'b1, 16'h0001, 16'h0001, 16'h0001, 1'b0, '0};
    dir_rows[14] = '{FUNC_CHECK,  1'b0, 16'h0001, 16'h0001, 16'h0001, 1'b0, '0};
    dir_rows[15] = '{FUNC_CHECK,  1'b0, 16'h0001, 16'h0002, 16'h0001, 1'b0, '0};
    dir_rows[16] = '{FUNC_CHECK,  1'b1, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, '0};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_beat(dir_rows[i].f, dir_rows[i].allow, dir_rows[i].subj, dir_rows[i].oper,
                dir_rows[i].obj, dir_rows[i].typed, dir_rows[i].want);
    wait_for_results();

    // one in three appends: table fills partway through, later appends hit the full case
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_phase = (n >= 100 && n < 140) || (n >= 400 && n < 440);
      if (n == 250) wait_for_results();
      f = ($urandom_range(0, 2) == 0) ? FUNC_APPEND : FUNC_CHECK;
      send_beat(f, 1'($urandom_range(0, 1)), pick_id(0, f == FUNC_APPEND),
                pick_id(1, f == FUNC_APPEND), pick_id(2, f == FUNC_APPEND), 1'b0, '0);
    end
    quiet_phase = 1'b0;

    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (2 * MAX_RULES_DEF + 8) @(posedge clk);

    $display("covered %0d checks (%0d decided by a rule), %0d appends stored, %0d refused full",
             n_checks, n_hits, n_appends, n_full);
    $display("%0d failures, %0d verdicts left unmatched", fail_count, pending_verdicts.size());
    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("wildcard_rule_access_check test passed");
    end else begin
      $display("wildcard_rule_access_check test failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/wac_pkg.sv
src/wac_cell.sv
src/wildcard_rule_access_check.sv
tb/wildcard_rule_access_check_tb.sv
